// ===== hdl/ltc_pkg.sv =====
// Shared types, character classes and keyword tables for the token scanner.
package ltc_pkg;

	// Result kinds as they appear on the output tuser
	typedef enum logic [2:0] {
		KIND_KEYWORD = 3'd0,
		KIND_IDENT   = 3'd1,
		KIND_NUMBER  = 3'd2,
		KIND_OPER    = 3'd3,
		KIND_SEP     = 3'd4,
		KIND_SUMMARY = 3'd5
	} kind_t;

	// Scanner position relative to tokens
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_NUM  = 2'd2
	} mode_t;

	localparam int NUM_KW     = 6;
	localparam int KW_MAX_LEN = 6;
	localparam int NUM_KINDS  = 5;

	// Keywords: int, if, else, while, for, return
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6};
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"}
	};

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} kw_hit_t;

	function automatic logic is_alpha(logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_oper(logic [7:0] b);
		return (b == "+") || (b == "-") || (b == "*") || (b == "/") ||
			(b == "=") || (b == "%");
	endfunction

	function automatic logic is_sep(logic [7:0] b);
		return (b == "(") || (b == ")") || (b == ";") || (b == "{") ||
			(b == "}") || (b == "[") || (b == "]") || (b == ",");
	endfunction

	// Drop candidates whose character at position idx differs from b
	function automatic logic [NUM_KW-1:0] kw_filter(logic [NUM_KW-1:0] cand,
		logic [7:0] idx, logic [7:0] b);
		logic [NUM_KW-1:0] res;
		res = '0;
		for (int i = 0; i < NUM_KW; i++) begin
			if (cand[i] && (idx < 8'(KW_LEN[i]))) begin
				res[i] = (KW_TEXT[i][idx[2:0]] == b);
			end
		end
		return res;
	endfunction

	// Lowest-numbered surviving candidate whose length equals the token length
	function automatic kw_hit_t kw_match(logic [NUM_KW-1:0] cand, logic [7:0] len);
		kw_hit_t res;
		res = '0;
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			if (cand[i] && (len == 8'(KW_LEN[i]))) begin
				res.hit = 1'b1;
				res.idx = 3'(i);
			end
		end
		return res;
	endfunction

endpackage

// ===== hdl/ltc_front.sv =====
// Front end: accepts bytes, tracks the open token and queues token and symbol events.
module ltc_front #(
	parameter int MAX_TOKEN_LENGTH = 63,
	parameter int POSITION_BITS    = 32,
	parameter int LEN_BITS         = 6,
	parameter int ENT_W            = 2 * 32 + 6 + 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_action,
	input  logic [7:0]       in_byte,
	output logic             ent_valid,
	input  logic             ent_ready,
	output logic [ENT_W-1:0] ent
);

	typedef struct packed {
		logic                     tok_vld;
		ltc_pkg::kind_t           tok_kind;
		logic [POSITION_BITS-1:0] tok_start;
		logic [LEN_BITS-1:0]      tok_len;
		logic [2:0]               tok_kwi;
		logic                     sec_vld;
		ltc_pkg::kind_t           sec_kind;
		logic [7:0]               sec_sym;
		logic [POSITION_BITS-1:0] sec_start;
	} entry_t;

	localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LENGTH);

	ltc_pkg::mode_t                   mode_q, mode_n;
	logic [LEN_BITS-1:0]              len_q, len_n, len_grow;
	logic [POSITION_BITS-1:0]         start_q, start_n;
	logic [POSITION_BITS-1:0]         pos_q, pos_n;
	logic [ltc_pkg::NUM_KW-1:0]       cand_q, cand_n;
	ltc_pkg::kw_hit_t                 hit;
	entry_t                           e;
	logic                             acc;
	logic                             rescan;

	assign in_ready  = ent_ready;
	assign acc       = in_valid && ent_ready;
	assign ent_valid = acc && (e.tok_vld || e.sec_vld);
	assign ent       = e;

	assign len_grow = (len_q < LEN_MAX) ? len_q + 1'b1 : len_q;
	assign hit      = ltc_pkg::kw_match(cand_q, 8'(len_q));

	// Scan step: close or extend the open token, then rescan the byte if needed
	always_comb begin
		e       = '0;
		mode_n  = mode_q;
		len_n   = len_q;
		start_n = start_q;
		cand_n  = cand_q;
		pos_n   = pos_q;
		rescan  = 1'b0;

		// closing token, used whenever tok_vld is set
		e.tok_start = start_q;
		e.tok_len   = len_q;
		if (mode_q == ltc_pkg::MODE_WORD) begin
			e.tok_kind = hit.hit ? ltc_pkg::KIND_KEYWORD : ltc_pkg::KIND_IDENT;
			e.tok_kwi  = hit.hit ? hit.idx : 3'd0;
		end else begin
			e.tok_kind = ltc_pkg::KIND_NUMBER;
			e.tok_kwi  = 3'd0;
		end

		if (in_action) begin
			// end of stream: flush, summarize, clear
			e.tok_vld   = (mode_q != ltc_pkg::MODE_IDLE);
			e.sec_vld   = 1'b1;
			e.sec_kind  = ltc_pkg::KIND_SUMMARY;
			e.sec_start = pos_q;
			mode_n      = ltc_pkg::MODE_IDLE;
			len_n       = '0;
			start_n     = '0;
			cand_n      = '1;
			pos_n       = '0;
		end else begin
			pos_n = pos_q + 1'b1;
			unique case (mode_q)
				ltc_pkg::MODE_WORD: begin
					if (ltc_pkg::is_alpha(in_byte) || ltc_pkg::is_digit(in_byte)) begin
						cand_n = ltc_pkg::kw_filter(cand_q, 8'(len_q), in_byte);
						len_n  = len_grow;
					end else begin
						e.tok_vld = 1'b1;
						rescan    = 1'b1;
					end
				end
				ltc_pkg::MODE_NUM: begin
					if (ltc_pkg::is_digit(in_byte)) begin
						len_n = len_grow;
					end else begin
						e.tok_vld = 1'b1;
						rescan    = 1'b1;
					end
				end
				default: begin
					rescan = 1'b1;
				end
			endcase

			// byte seen from outside any token
			if (rescan) begin
				mode_n = ltc_pkg::MODE_IDLE;
				if (ltc_pkg::is_alpha(in_byte)) begin
					mode_n  = ltc_pkg::MODE_WORD;
					start_n = pos_q;
					len_n   = LEN_BITS'(1);
					cand_n  = ltc_pkg::kw_filter('1, 8'd0, in_byte);
				end else if (ltc_pkg::is_digit(in_byte)) begin
					mode_n  = ltc_pkg::MODE_NUM;
					start_n = pos_q;
					len_n   = LEN_BITS'(1);
					cand_n  = '1;
				end else if (ltc_pkg::is_oper(in_byte)) begin
					e.sec_vld   = 1'b1;
					e.sec_kind  = ltc_pkg::KIND_OPER;
					e.sec_sym   = in_byte;
					e.sec_start = pos_q;
				end else if (ltc_pkg::is_sep(in_byte)) begin
					e.sec_vld   = 1'b1;
					e.sec_kind  = ltc_pkg::KIND_SEP;
					e.sec_sym   = in_byte;
					e.sec_start = pos_q;
				end
			end
		end
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ltc_pkg::MODE_IDLE;
			len_q   <= '0;
			start_q <= '0;
			cand_q  <= '1;
			pos_q   <= '0;
		end else if (acc) begin
			mode_q  <= mode_n;
			len_q   <= len_n;
			start_q <= start_n;
			cand_q  <= cand_n;
			pos_q   <= pos_n;
		end
	end

endmodule

// ===== hdl/ltc_queue.sv =====
// Small register FIFO between the scanner front end and the result back end.
module ltc_queue #(
	parameter int W          = 8,
	parameter int DEPTH_LOG2 = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [W-1:0]          mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wptr_q, rptr_q;
	logic [DEPTH_LOG2:0]   cnt_q;
	logic                  push, pop;

	assign wr_ready = (cnt_q != (DEPTH_LOG2 + 1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/ltc_back.sv =====
// Back end: expands queued events into results, keeps kind totals, drives output register.
module ltc_back #(
	parameter int POSITION_BITS = 32,
	parameter int LEN_BITS      = 6,
	parameter int COUNT_BITS    = 16,
	parameter int ENT_W         = 2 * 32 + 6 + 19,
	parameter int DATA_W        = 11 + 32 + 6 + 5 * 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ent_valid,
	output logic              ent_ready,
	input  logic [ENT_W-1:0]  ent,
	output logic              out_valid,
	input  logic              out_ready,
	output ltc_pkg::kind_t    out_kind,
	output logic [DATA_W-1:0] out_data,
	output logic              out_last
);

	typedef struct packed {
		logic                     tok_vld;
		ltc_pkg::kind_t           tok_kind;
		logic [POSITION_BITS-1:0] tok_start;
		logic [LEN_BITS-1:0]      tok_len;
		logic [2:0]               tok_kwi;
		logic                     sec_vld;
		ltc_pkg::kind_t           sec_kind;
		logic [7:0]               sec_sym;
		logic [POSITION_BITS-1:0] sec_start;
	} entry_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	entry_t                   e;
	logic                     valid_q;
	logic                     phase_q;
	ltc_pkg::kind_t           kind_q;
	logic [DATA_W-1:0]        data_q;
	logic                     last_q;
	logic [COUNT_BITS-1:0]    cnt_q [ltc_pkg::NUM_KINDS];
	logic [COUNT_BITS-1:0]    cnt_n [ltc_pkg::NUM_KINDS];
	logic                     load, first, pop;
	ltc_pkg::kind_t           kind_c;
	logic [7:0]               sym_c;
	logic [POSITION_BITS-1:0] start_c;
	logic [LEN_BITS-1:0]      len_c;
	logic [2:0]               kwi_c;
	logic                     last_c;
	logic [DATA_W-1:0]        data_c;

	assign e         = ent;
	assign load      = (!valid_q || out_ready) && ent_valid;
	assign first     = e.tok_vld && !phase_q;
	assign pop       = load && !(first && e.sec_vld);
	assign ent_ready = pop;

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

	// Pick the token or the symbol/summary half of the entry
	always_comb begin
		if (first) begin
			kind_c  = e.tok_kind;
			sym_c   = 8'd0;
			start_c = e.tok_start;
			len_c   = e.tok_len;
			kwi_c   = e.tok_kwi;
			last_c  = !e.sec_vld;
		end else begin
			kind_c  = e.sec_kind;
			sym_c   = e.sec_sym;
			start_c = e.sec_start;
			len_c   = (e.sec_kind == ltc_pkg::KIND_SUMMARY) ? '0 : LEN_BITS'(1);
			kwi_c   = 3'd0;
			last_c  = 1'b1;
		end
	end

	// Saturating totals including this result
	always_comb begin
		for (int k = 0; k < ltc_pkg::NUM_KINDS; k++) begin
			if ((kind_c == 3'(k)) && (cnt_q[k] != CNT_MAX)) begin
				cnt_n[k] = cnt_q[k] + 1'b1;
			end else begin
				cnt_n[k] = cnt_q[k];
			end
		end
		data_c = {cnt_n[4], cnt_n[3], cnt_n[2], cnt_n[1], cnt_n[0],
			kwi_c, len_c, start_c, sym_c};
	end

	// Control: output valid, entry phase and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
			for (int k = 0; k < ltc_pkg::NUM_KINDS; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				phase_q <= first && e.sec_vld;
				for (int k = 0; k < ltc_pkg::NUM_KINDS; k++) begin
					cnt_q[k] <= (kind_c == ltc_pkg::KIND_SUMMARY) ? '0 : cnt_n[k];
				end
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_c;
			data_q <= data_c;
			last_q <= last_c;
		end
	end

endmodule

// ===== hdl/lexical_token_classifier_core.sv =====
// Top level of the byte-serial lexical scanner: front end, event queue, back end.
//
// Input stream (s_*): one request per byte; s_tuser = 1 marks end of stream
// (s_tdata ignored). Output stream (m_*): up to two token, symbol or summary results
// per request on the bus; m_tuser holds the kind, m_tlast marks the final result
// of an input request.
// Each byte is classified in the cycle it is accepted; its results are registered
// in the event queue and then in the output register, which loads when free.
// Throughput is one byte per cycle while the queue has room. A byte that closes
// a word or number and is itself an operator or separator, or an end of stream
// with an open token, gives two results from one entry; a four-entry event queue
// absorbs these so the input keeps moving until the queue fills.
// When the receiver stalls, the output register holds its result, the queue
// fills, and s_tready drops once all four entries are in use.
// Reset clears the scanner state, byte position, queue and kind totals; the
// end-of-stream request clears all but the queue after emitting its summary.
module lexical_token_classifier_core #(
	parameter int MAX_TOKEN_LENGTH = 63,
	parameter int COUNT_BITS       = 16,
	parameter int POSITION_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // byte_req
	input  logic                s_tuser,  // action
	output logic                m_tvalid,
	input  logic                m_tready,
	// symbol, token_start, token_length, keyword_index, keyword_total,
	// identifier_total, number_total, operator_total, separator_total, zero fill
	output logic [((11 + POSITION_BITS + $clog2(MAX_TOKEN_LENGTH + 1) + 5 * COUNT_BITS + 7)
		/ 8) * 8 - 1:0] m_tdata,
	output logic [2:0]          m_tuser,  // kind
	output logic                m_tlast
);

	localparam int LEN_BITS = $clog2(MAX_TOKEN_LENGTH + 1);
	localparam int ENT_W    = 2 * POSITION_BITS + LEN_BITS + 19;
	localparam int DATA_W   = 11 + POSITION_BITS + LEN_BITS + 5 * COUNT_BITS;
	localparam int TDATA_W  = ((DATA_W + 7) / 8) * 8;
	localparam int LEN_LO   = 8 + POSITION_BITS;
	localparam int KWI_LO   = LEN_LO + LEN_BITS;

	logic              fe_valid, fe_ready;
	logic [ENT_W-1:0]  fe_ent;
	logic              be_valid, be_ready;
	logic [ENT_W-1:0]  be_ent;
	ltc_pkg::kind_t    out_kind;
	logic [DATA_W-1:0] out_data;

	ltc_front #(
		.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
		.POSITION_BITS(POSITION_BITS),
		.LEN_BITS(LEN_BITS),
		.ENT_W(ENT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_action(s_tuser),
		.in_byte(s_tdata),
		.ent_valid(fe_valid),
		.ent_ready(fe_ready),
		.ent(fe_ent)
	);

	ltc_queue #(
		.W(ENT_W),
		.DEPTH_LOG2(2)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fe_valid),
		.wr_ready(fe_ready),
		.wr_data(fe_ent),
		.rd_valid(be_valid),
		.rd_ready(be_ready),
		.rd_data(be_ent)
	);

	ltc_back #(
		.POSITION_BITS(POSITION_BITS),
		.LEN_BITS(LEN_BITS),
		.COUNT_BITS(COUNT_BITS),
		.ENT_W(ENT_W),
		.DATA_W(DATA_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ent_valid(be_valid),
		.ent_ready(be_ready),
		.ent(be_ent),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind(out_kind),
		.out_data(out_data),
		.out_last(m_tlast)
	);

	assign m_tuser = out_kind;

	// Zero-fill the packed payload to whole bytes
	always_comb begin
		m_tdata = TDATA_W'(out_data);
	end

	// A summary always closes its request
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ltc_pkg::KIND_SUMMARY) |-> m_tlast)
		else $error("summary result without tlast");

	// Only a closed word or number can be followed by a second result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tuser == ltc_pkg::KIND_KEYWORD) ||
			(m_tuser == ltc_pkg::KIND_IDENT) || (m_tuser == ltc_pkg::KIND_NUMBER))
		else $error("non-final result is not a word or number token");

	// Operators and separators are one character long
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == ltc_pkg::KIND_OPER) || (m_tuser == ltc_pkg::KIND_SEP))
			|-> (m_tdata[LEN_LO +: LEN_BITS] == LEN_BITS'(1)))
		else $error("symbol result with length other than one");

	// Keyword index is zero except on keywords
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ltc_pkg::KIND_KEYWORD) |-> (m_tdata[KWI_LO +: 3] == 3'd0))
		else $error("keyword index set on a non-keyword result");

endmodule

// ===== tb/lexical_token_classifier_checker.sv =====
// Scoreboard for the token scanner: predicts results from accepted requests and checks them.
module lexical_token_classifier_checker #(
	parameter int DATA_W = 136
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic [2:0]        m_tuser,
	input  logic              m_tlast,
	output int                mismatches,
	output int                outstanding
);

	// Bit offsets of the result fields in m_tdata
	localparam int SYMBOL_LO  = 0;
	localparam int START_LO   = 8;
	localparam int LENGTH_LO  = 40;
	localparam int KWIDX_LO   = 46;
	localparam int TOTALS_LO  = 49;
	localparam int FILL_LO    = 129;
	localparam logic [5:0]  LENGTH_MAX = 6'd63;
	localparam logic [15:0] TOTAL_MAX  = 16'hFFFF;

	typedef struct packed {
		ltc_pkg::kind_t   kind;
		logic [7:0]       symbol;
		logic [31:0]      start;
		logic [5:0]       length;
		logic [2:0]       kw_index;
		logic [4:0][15:0] totals;
		logic             last;
	} token_result_t;

	string keyword_text [6] = '{"int", "if", "else", "while", "for", "return"};
	string total_names [5] = '{"keyword_total", "identifier_total", "number_total",
		"operator_total", "separator_total"};
	string operator_chars = "+-*/=%";
	string separator_chars = "();{}[],";

	// Scanner state mirrored by the predictor
	ltc_pkg::mode_t   scan_mode;
	logic [5:0]       open_len;
	logic [31:0]      open_start;
	logic [5:0]       kw_cand;
	logic [31:0]      byte_pos;
	logic [4:0][15:0] kind_count;

	token_result_t expected_tokens [$];
	int            fail_total = 0;

	function automatic logic is_letter(logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
	endfunction

	function automatic logic is_numeral(logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic in_charset(string chars, logic [7:0] b);
		for (int k = 0; k < chars.len(); k++) begin
			if (chars[k] == b) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Keep only keywords whose character at position idx is b
	function automatic logic [5:0] narrow_candidates(logic [5:0] cand, logic [5:0] idx,
		logic [7:0] b);
		logic [5:0] kept;
		kept = '0;
		for (int k = 0; k < 6; k++) begin
			if (cand[k] && (int'(idx) < keyword_text[k].len()) &&
				(keyword_text[k][int'(idx)] == b)) begin
				kept[k] = 1'b1;
			end
		end
		return kept;
	endfunction

	function automatic void clear_scanner();
		scan_mode  = ltc_pkg::MODE_IDLE;
		open_len   = '0;
		open_start = '0;
		kw_cand    = 6'h3F;
		byte_pos   = '0;
		kind_count = '0;
	endfunction

	// Bump the total for this kind and snapshot all totals into a result
	function automatic token_result_t make_result(ltc_pkg::kind_t kind, logic [7:0] sym,
		logic [31:0] start, logic [5:0] len, logic [2:0] kwi);
		token_result_t r;
		if ((kind != ltc_pkg::KIND_SUMMARY) && (kind_count[kind] != TOTAL_MAX)) begin
			kind_count[kind] = kind_count[kind] + 16'd1;
		end
		r.kind     = kind;
		r.symbol   = sym;
		r.start    = start;
		r.length   = len;
		r.kw_index = kwi;
		r.totals   = kind_count;
		r.last     = 1'b0;
		return r;
	endfunction

	// Result for the word or number that is open now
	function automatic token_result_t closing_result();
		if (scan_mode == ltc_pkg::MODE_WORD) begin
			for (int k = 0; k < 6; k++) begin
				if (kw_cand[k] && (int'(open_len) == keyword_text[k].len())) begin
					return make_result(ltc_pkg::KIND_KEYWORD, 8'h00, open_start, open_len,
						3'(k));
				end
			end
			return make_result(ltc_pkg::KIND_IDENT, 8'h00, open_start, open_len, 3'd0);
		end
		return make_result(ltc_pkg::KIND_NUMBER, 8'h00, open_start, open_len, 3'd0);
	endfunction

	function automatic void grow_token();
		if (open_len != LENGTH_MAX) begin
			open_len = open_len + 6'd1;
		end
	endfunction

	// Advance the scanner by one request and queue the results it causes
	function automatic void predict_request(logic eos, logic [7:0] b);
		token_result_t found [2];
		int            n;
		logic [31:0]   pos;
		n   = 0;
		pos = byte_pos;
		if (eos) begin
			if (scan_mode != ltc_pkg::MODE_IDLE) begin
				found[n] = closing_result();
				n++;
			end
			found[n] = make_result(ltc_pkg::KIND_SUMMARY, 8'h00, pos, 6'd0, 3'd0);
			n++;
			clear_scanner();
		end else begin
			byte_pos = byte_pos + 32'd1;
			if ((scan_mode == ltc_pkg::MODE_WORD) && (is_letter(b) || is_numeral(b))) begin
				kw_cand = narrow_candidates(kw_cand, open_len, b);
				grow_token();
			end else if ((scan_mode == ltc_pkg::MODE_NUM) && is_numeral(b)) begin
				grow_token();
			end else begin
				// closing byte is scanned again from outside any token
				if (scan_mode != ltc_pkg::MODE_IDLE) begin
					found[n] = closing_result();
					n++;
				end
				scan_mode = ltc_pkg::MODE_IDLE;
				if (is_letter(b)) begin
					scan_mode  = ltc_pkg::MODE_WORD;
					open_start = pos;
					open_len   = 6'd1;
					kw_cand    = narrow_candidates(6'h3F, 6'd0, b);
				end else if (is_numeral(b)) begin
					scan_mode  = ltc_pkg::MODE_NUM;
					open_start = pos;
					open_len   = 6'd1;
					kw_cand    = 6'h3F;
				end else if (in_charset(operator_chars, b)) begin
					found[n] = make_result(ltc_pkg::KIND_OPER, b, pos, 6'd1, 3'd0);
					n++;
				end else if (in_charset(separator_chars, b)) begin
					found[n] = make_result(ltc_pkg::KIND_SEP, b, pos, 6'd1, 3'd0);
					n++;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			found[k].last = (k == n - 1);
			expected_tokens.push_back(found[k]);
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_total++;
		end
	endfunction

	// Compare one delivered result with the oldest expectation
	function automatic void check_result();
		token_result_t want;
		if (expected_tokens.size() == 0) begin
			$error("result of kind %0d arrived with nothing expected", m_tuser);
			fail_total++;
			return;
		end
		want = expected_tokens.pop_front();
		compare_field("kind", 32'(want.kind), 32'(m_tuser));
		compare_field("symbol", 32'(want.symbol), 32'(m_tdata[SYMBOL_LO +: 8]));
		compare_field("token_start", want.start, m_tdata[START_LO +: 32]);
		compare_field("token_length", 32'(want.length), 32'(m_tdata[LENGTH_LO +: 6]));
		compare_field("keyword_index", 32'(want.kw_index), 32'(m_tdata[KWIDX_LO +: 3]));
		for (int k = 0; k < 5; k++) begin
			compare_field(total_names[k], 32'(want.totals[k]),
				32'(m_tdata[TOTALS_LO + 16 * k +: 16]));
		end
		compare_field("last", 32'(want.last), 32'(m_tlast));
		compare_field("zero fill", 32'd0, 32'(m_tdata[DATA_W-1:FILL_LO]));
	endfunction

	// Watch both channels on each rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			clear_scanner();
			expected_tokens.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (s_tvalid && s_tready) begin
				predict_request(s_tuser, s_tdata);
			end
			mismatches  <= fail_total;
			outstanding <= expected_tokens.size();
		end
	end

endmodule

// ===== tb/lexical_token_classifier_core_tb.sv =====
// Testbench top for the token scanner: clock, reset, stimulus, stalls and verdict.
module lexical_token_classifier_core_tb;

	localparam int TDATA_W = ((11 + 32 + 6 + 5 * 16 + 7) / 8) * 8;
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_EOS  = 1'b1;
	localparam int HOLD_CYCLES    = 80;
	localparam int TAIL_CYCLES    = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET    = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [2:0]         m_tuser;
	logic               m_tlast;
	logic               hold_off = 1'b0;

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int counted = 0;

	string keyword_text [6] = '{"int", "if", "else", "while", "for", "return"};
	string operator_chars = "+-*/=%";
	string separator_chars = "();{}[],";
	string blank_chars = " \t\n\r";
	string delimiter_chars = " ;,(=+";

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lexical_token_classifier_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lexical_token_classifier_checker #(
		.DATA_W (TDATA_W)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one request, with random idle cycles first, and wait until it is taken
	task automatic send_request(logic act, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		counted++;
	endtask

	task automatic send_text(string text);
		for (int k = 0; k < text.len(); k++) begin
			send_request(ACT_BYTE, text[k]);
		end
	endtask

	// Stop offering and wait until every expected result has been delivered
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_letter();
		if ($urandom_range(1)) begin
			return 8'("a" + $urandom_range(25));
		end
		return 8'("A" + $urandom_range(25));
	endfunction

	function automatic logic [7:0] random_digit();
		return 8'("0" + $urandom_range(9));
	endfunction

	function automatic logic [7:0] random_alnum();
		if ($urandom_range(3) == 0) begin
			return random_digit();
		end
		return random_letter();
	endfunction

	// One random piece of source text: mostly tokens, some blanks, noise and stream ends
	task automatic send_fragment();
		logic [7:0] chunk [$];
		string      word;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			// keyword, sometimes bent into a near miss
			word = keyword_text[$urandom_range(5)];
			for (int k = 0; k < word.len(); k++) begin
				chunk.push_back(word[k]);
			end
			case ($urandom_range(5))
				0: chunk[$urandom_range(chunk.size() - 1)] ^= 8'h20;
				1: chunk.push_back(random_alnum());
				2: void'(chunk.pop_back());
				default: ;
			endcase
		end else if (pick < 35) begin
			chunk.push_back(random_letter());
			repeat ($urandom_range(7)) chunk.push_back(random_alnum());
		end else if (pick < 50) begin
			repeat ($urandom_range(1, 6)) chunk.push_back(random_digit());
		end else if (pick < 65) begin
			chunk.push_back(operator_chars[$urandom_range(5)]);
		end else if (pick < 78) begin
			chunk.push_back(separator_chars[$urandom_range(7)]);
		end else if (pick < 88) begin
			chunk.push_back(blank_chars[$urandom_range(3)]);
		end else if (pick < 95) begin
			chunk.push_back(8'($urandom_range(255)));
		end else if (pick < 97) begin
			// token long enough to saturate its length
			if ($urandom_range(1)) begin
				chunk.push_back(random_letter());
				repeat ($urandom_range(63, 75)) chunk.push_back(random_alnum());
			end else begin
				repeat ($urandom_range(64, 76)) chunk.push_back(random_digit());
			end
		end else begin
			send_request(ACT_EOS, 8'($urandom_range(255)));
			return;
		end
		if ((pick < 50) && $urandom_range(1)) begin
			chunk.push_back(delimiter_chars[$urandom_range(5)]);
		end
		foreach (chunk[k]) begin
			send_request(ACT_BYTE, chunk[k]);
		end
	endtask

	// Receiver: random stalls, or one long hold-off when asked
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Give up when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: skipped extremes, every kind, two-result closes, case, stream ends
		send_idle_pct = 7;
		recv_idle_pct = 87;
		send_request(ACT_BYTE, 8'h00);
		send_text("if(x1)=9;Int");
		send_request(ACT_BYTE, 8'hFF);
		send_request(ACT_EOS, 8'hA5);
		send_request(ACT_EOS, 8'h00);
		send_text("return");
		send_request(ACT_EOS, 8'h5A);
		send_text("7%");

		// long receiver hold-off while words closed by separators pile up
		hold_off <= 1'b1;
		repeat (12) begin
			send_request(ACT_BYTE, random_letter());
			send_request(ACT_BYTE, separator_chars[$urandom_range(7)]);
		end
		drain_results();

		while (counted < ITEM_TARGET / 3) begin
			send_fragment();
		end

		send_idle_pct = 87;
		recv_idle_pct = 7;
		while (counted < 2 * ITEM_TARGET / 3) begin
			send_fragment();
		end
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (counted < ITEM_TARGET) begin
			send_fragment();
		end
		send_request(ACT_EOS, 8'h00);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if ((mismatches == 0) && (outstanding == 0)) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
